[sv/crr_pkg.sv]
// Shared constants and control types for the cell-range reference converter.
package crr_pkg;

  // Character width of the stream
  localparam int CH_W = 16;

  // Characters that steer the conversion
  localparam logic [CH_W-1:0] CH_DOLLAR = 16'h0024;
  localparam logic [CH_W-1:0] CH_DOT    = 16'h002E;
  localparam logic [CH_W-1:0] CH_COLON  = 16'h003A;
  localparam logic [CH_W-1:0] CH_SPACE  = 16'h0020;
  localparam logic [CH_W-1:0] CH_APOS   = 16'h0027;
  localparam logic [CH_W-1:0] CH_BANG   = 16'h0021;
  localparam logic [CH_W-1:0] CH_SEMI   = 16'h003B;
  localparam logic [CH_W-1:0] CH_NONE   = 16'h0000;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic take;       // input item accepted this cycle
    logic rd_en;      // read one segment entry
    logic load_char;  // load the read entry into the output register
    logic load_tail;  // load the separator or end marker
    logic last;       // loaded result is the last one of the item
  } crr_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic tail;      // item ends with a separator or a bare end marker
    logic no_chars;  // item emits no stored characters
  } crr_stat_t;

endpackage

[sv/crr_in_if.sv]
// Input channel: one reference character per item.
interface crr_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] ch;
  logic        final_char;

  modport source (output valid, output ch, output final_char, input ready);
  modport sink (input valid, input ch, input final_char, output ready);
endinterface

[sv/crr_out_if.sv]
// Output channel: one converted character or end marker per item.
interface crr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_ch;
  logic        has_char;
  logic        run_end;
  logic        expr_end;
  logic        overflowed;

  modport source (output valid, output out_ch, output has_char, output run_end,
                  output expr_end, output overflowed, input ready);
  modport sink (input valid, input out_ch, input has_char, input run_end,
                input expr_end, input overflowed, output ready);
endinterface

[sv/crr_datapath.sv]
// Datapath: scan rules, segment memory, per-item plan and output register.
module crr_datapath #(
  parameter int SEGMENT_DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [crr_pkg::CH_W-1:0]              ch,
  input  logic                                  final_char,
  input  crr_pkg::crr_cmd_t                     cmd,
  input  logic [$clog2(SEGMENT_DEPTH)-1:0]      rd_addr,
  output crr_pkg::crr_stat_t                    stat,
  output logic [$clog2(SEGMENT_DEPTH+1)-1:0]    plan_len,
  output logic [crr_pkg::CH_W-1:0]              out_ch,
  output logic                                  has_char,
  output logic                                  run_end,
  output logic                                  expr_end,
  output logic                                  overflowed
);
  import crr_pkg::*;

  localparam int IDX_W = $clog2(SEGMENT_DEPTH);
  localparam int LEN_W = $clog2(SEGMENT_DEPTH + 1);
  localparam logic [LEN_W-1:0] DEPTH = LEN_W'(SEGMENT_DEPTH);

  typedef enum logic [2:0] {
    M_START  = 3'd0,
    M_QUOTED = 3'd1,
    M_QSEEN  = 3'd2,
    M_COLON  = 3'd3,
    M_DHELD  = 3'd4
  } mode_t;

  // Segment memory
  logic [CH_W-1:0] mem [SEGMENT_DEPTH];
  logic [CH_W-1:0] rd_data;

  // Scan state
  logic [LEN_W-1:0] len;
  mode_t            mode;
  logic             range_seen;
  logic             first_pending;
  logic             drop;

  // Plan of the item in flight
  logic [CH_W-1:0]  plan_tail_ch;
  logic             plan_sep;
  logic             plan_tail;
  logic             plan_fin;
  logic             plan_drop;

  // Decode results
  mode_t            mode_next;
  logic [LEN_W-1:0] len1;
  logic [LEN_W-1:0] len_next;
  logic [LEN_W-1:0] emit_n;
  logic             range_next;
  logic             drop_next;
  logic             run_start;
  logic             q_push;
  logic             push_dollar;
  logic             sc_push;
  logic             sep;
  logic             clear;
  logic             full;
  logic             wr_en;
  logic [CH_W-1:0]  wr_data;
  logic [CH_W-1:0]  sep_ch;

  // Decode one character against the scan state
  always_comb begin
    mode_next   = mode;
    range_next  = range_seen;
    run_start   = 1'b0;
    q_push      = 1'b0;
    push_dollar = 1'b0;
    sc_push     = 1'b0;
    sep         = 1'b0;
    clear       = 1'b0;
    sep_ch      = CH_NONE;

    if (first_pending) begin
      mode_next = M_START;
      run_start = (ch != CH_DOLLAR);
    end else begin
      case (mode)
        M_QUOTED: begin
          q_push    = 1'b1;
          mode_next = (ch == CH_APOS) ? M_QSEEN : M_QUOTED;
        end
        M_QSEEN: begin
          if (ch == CH_APOS) begin
            mode_next = M_QUOTED;
          end else begin
            run_start = 1'b1;
          end
        end
        M_COLON: begin
          if (ch == CH_DOLLAR && !final_char) begin
            mode_next = M_DHELD;
          end else begin
            run_start = 1'b1;
          end
        end
        M_DHELD: begin
          push_dollar = (ch == CH_DOT);
          run_start   = 1'b1;
        end
        default: begin
          run_start = 1'b1;
        end
      endcase
    end

    // Push from quotes or the held dollar comes first
    full = (len >= DEPTH);
    len1 = ((q_push || push_dollar) && !full) ? len + LEN_W'(1) : len;

    // Rules of start mode
    if (run_start) begin
      mode_next = M_START;
      case (ch)
        CH_APOS: begin
          sc_push   = 1'b1;
          mode_next = M_QUOTED;
        end
        CH_DOT: begin
          sep    = (len1 != '0) && !range_seen;
          sep_ch = CH_BANG;
          clear  = 1'b1;
        end
        CH_COLON: begin
          range_next = 1'b1;
          sep        = 1'b1;
          sep_ch     = CH_COLON;
          mode_next  = M_COLON;
        end
        CH_SPACE: begin
          sep    = 1'b1;
          sep_ch = CH_SEMI;
        end
        default: begin
          sc_push = 1'b1;
        end
      endcase
    end

    wr_en     = (q_push || push_dollar || sc_push) && !full;
    wr_data   = push_dollar ? CH_DOLLAR : ch;
    drop_next = drop || ((q_push || push_dollar || sc_push) && full);

    if (sep || clear) begin
      len_next = '0;
    end else if (sc_push && !full) begin
      len_next = len1 + LEN_W'(1);
    end else begin
      len_next = len1;
    end

    if (sep) begin
      emit_n = len1;
    end else if (final_char) begin
      emit_n = len_next;
    end else begin
      emit_n = '0;
    end
  end

  // Advance scan state on each accepted item, drop it all at expression end
  always_ff @(posedge clk) begin
    if (rst) begin
      len           <= '0;
      mode          <= M_START;
      range_seen    <= 1'b0;
      first_pending <= 1'b1;
      drop          <= 1'b0;
    end else if (cmd.take) begin
      if (final_char) begin
        len           <= '0;
        mode          <= M_START;
        range_seen    <= 1'b0;
        first_pending <= 1'b1;
        drop          <= 1'b0;
      end else begin
        len           <= len_next;
        mode          <= mode_next;
        range_seen    <= range_next;
        first_pending <= 1'b0;
        drop          <= drop_next;
      end
    end
  end

  // Hold the plan of the accepted item
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      plan_len     <= emit_n;
      plan_sep     <= sep;
      plan_tail_ch <= sep ? sep_ch : CH_NONE;
      plan_tail    <= sep || (final_char && emit_n == '0);
      plan_fin     <= final_char;
      plan_drop    <= drop_next;
    end
  end

  // Segment memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.take && wr_en) begin
      mem[len[IDX_W-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      out_ch     <= rd_data;
      has_char   <= 1'b1;
      run_end    <= cmd.last;
      expr_end   <= cmd.last && plan_fin;
      overflowed <= plan_drop;
    end else if (cmd.load_tail) begin
      out_ch     <= plan_tail_ch;
      has_char   <= plan_sep;
      run_end    <= cmd.last;
      expr_end   <= cmd.last && plan_fin;
      overflowed <= plan_drop;
    end
  end

  assign stat.tail     = plan_tail;
  assign stat.no_chars = (plan_len == '0);

`ifndef SYNTHESIS
  // Segment count never passes the memory depth
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= DEPTH)
    else $error("segment count beyond depth");

  // A fresh expression starts with empty segment and cleared flags
  a_fresh_expr: assert property (@(posedge clk) disable iff (rst)
    first_pending |-> (len == '0 && !range_seen && !drop))
    else $error("expression state not cleared");
`endif

endmodule

[sv/crr_ctrl.sv]
// Sequencer: takes items, steps through segment reads and loads results.
module crr_ctrl #(
  parameter int SEGMENT_DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  input  crr_pkg::crr_stat_t                    stat,
  input  logic [$clog2(SEGMENT_DEPTH+1)-1:0]    plan_len,
  output crr_pkg::crr_cmd_t                     cmd,
  output logic [$clog2(SEGMENT_DEPTH)-1:0]      rd_addr
);
  import crr_pkg::*;

  localparam int IDX_W = $clog2(SEGMENT_DEPTH);
  localparam int LEN_W = $clog2(SEGMENT_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLAN,
    S_READ,
    S_LOAD,
    S_TAIL
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] idx;
  logic             out_free;
  logic             idx_last;

  assign out_free = !out_valid || out_ready;
  assign idx_last = (LEN_W'(idx) + LEN_W'(1) == plan_len);
  assign in_ready = (state == S_IDLE);
  assign rd_addr  = idx;

  // Commands for the current state
  always_comb begin
    cmd           = '0;
    cmd.take      = (state == S_IDLE) && in_valid;
    cmd.rd_en     = (state == S_READ);
    cmd.load_char = (state == S_LOAD) && out_free;
    cmd.load_tail = (state == S_TAIL) && out_free;
    cmd.last      = (state == S_TAIL) || (idx_last && !stat.tail);
  end

  // State, read index and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_char || cmd.load_tail) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_PLAN;
          end
        end
        S_PLAN: begin
          idx <= '0;
          if (!stat.no_chars) begin
            state <= S_READ;
          end else if (stat.tail) begin
            state <= S_TAIL;
          end else begin
            state <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            if (idx_last) begin
              state <= stat.tail ? S_TAIL : S_IDLE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_READ;
            end
          end
        end
        S_TAIL: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A result is loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_char || cmd.load_tail) |-> out_free)
    else $error("output register overwritten");

  // Reads stay inside the planned segment
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD || state == S_READ) |-> (LEN_W'(idx) < plan_len))
    else $error("read beyond planned segment");

  // An accepted item blocks the input for the next cycle
  a_take_block: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> !in_ready)
    else $error("input taken twice in a row");
`endif

endmodule

[sv/cell_range_reference_import.sv]
// Top level of the cell-range reference converter.
//
// Usage: the chars channel carries one 16-bit character per item, with
// final_char set on the last character of an expression. The result channel
// carries the converted reference, one character per item; run_end marks the
// last result caused by an input item, expr_end the last of the expression.
// An expression whose last step emits nothing yields one bare end marker
// (has_char low). overflowed reports characters dropped past the segment
// buffer of SEGMENT_DEPTH entries.
// Sequence: an input item is taken in the idle state and planned in the plan
// state; each stored character then passes a memory read step and an output
// load step, and a separator or end marker takes one more load step. An item
// that emits nothing returns from the plan state to idle. The read and load
// steps of the sequencer do not overlap, and the block takes no new input
// item until every result of the last one is loaded.
// Reset: clears scan state, segment count and output valid; the segment
// memory is not cleared. When the receiver stalls, the sequencer holds the
// pending read and the input stays blocked until all results are loaded.
module cell_range_reference_import #(
  parameter int SEGMENT_DEPTH = 32
) (
  input logic       clk,
  input logic       rst,
  crr_in_if.sink    chars,
  crr_out_if.source result
);
  import crr_pkg::*;

  localparam int IDX_W = $clog2(SEGMENT_DEPTH);
  localparam int LEN_W = $clog2(SEGMENT_DEPTH + 1);

  crr_cmd_t         cmd;
  crr_stat_t        stat;
  logic [LEN_W-1:0] plan_len;
  logic [IDX_W-1:0] rd_addr;

  // Sequencer
  crr_ctrl #(
    .SEGMENT_DEPTH(SEGMENT_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chars.valid),
    .in_ready  (chars.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .plan_len  (plan_len),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  // Datapath
  crr_datapath #(
    .SEGMENT_DEPTH(SEGMENT_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ch         (chars.ch),
    .final_char (chars.final_char),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .stat       (stat),
    .plan_len   (plan_len),
    .out_ch     (result.out_ch),
    .has_char   (result.has_char),
    .run_end    (result.run_end),
    .expr_end   (result.expr_end),
    .overflowed (result.overflowed)
  );

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the cell-range reference converter.
`timescale 1ns / 1ps

module tb_top;
  import crr_pkg::*;

  localparam int SEG_DEPTH      = 32;
  localparam int RESET_CYCLES   = 12;
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES   = 100;   // longer than one item with a full segment takes to drain
  localparam int WATCHDOG_LIMIT = 1500;  // cycles with no item on either side
  localparam int PRINT_CAP      = 30;

  typedef enum logic [2:0] {
    SCAN_START       = 3'd0,
    SCAN_QUOTED      = 3'd1,
    SCAN_QUOTE_SEEN  = 3'd2,
    SCAN_COLON       = 3'd3,
    SCAN_DOLLAR_HELD = 3'd4
  } scan_mode_t;

  typedef struct packed {
    logic [CH_W-1:0] out_ch;
    logic            has_char;
    logic            run_end;
    logic            expr_end;
    logic            overflowed;
  } conv_result_t;

  logic clk = 1'b0;
  logic rst;

  crr_in_if  chars_if ();
  crr_out_if res_if ();

  cell_range_reference_import #(
    .SEGMENT_DEPTH(SEG_DEPTH)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .chars (chars_if),
    .result(res_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Converter state mirrored for prediction
  logic [CH_W-1:0] seg_mem [SEG_DEPTH];
  int              seg_count;
  scan_mode_t      mode;
  bit              range_seen;
  bit              first_pending;
  bit              dropped;
  logic [CH_W:0]   step_out [$];   // {has_char, ch} produced by one item
  conv_result_t    converted_q [$];

  // Stimulus control and bookkeeping
  logic [CH_W-1:0] expr_buf [$];
  bit tx_idle;
  bit rx_idle;
  bit hold_req;
  int hold_left;
  int stall_left;
  int stuck_cycles;
  int items_sent;
  int exprs_sent;
  int results_checked;
  int overflow_exprs;
  int mismatches;

  // ---------------------------------------------------------------- predictor

  function void clear_expr();
    seg_count     = 0;
    mode          = SCAN_START;
    range_seen    = 1'b0;
    first_pending = 1'b1;
    dropped       = 1'b0;
  endfunction

  function void seg_push(logic [CH_W-1:0] c);
    if (seg_count < SEG_DEPTH) begin
      seg_mem[seg_count] = c;
      seg_count++;
    end else begin
      dropped = 1'b1;
    end
  endfunction

  function void seg_flush();
    for (int i = 0; i < seg_count; i++) step_out.push_back({1'b1, seg_mem[i]});
    seg_count = 0;
  endfunction

  // Apply the start-mode rules to one character
  function void plain_char(logic [CH_W-1:0] c);
    mode = SCAN_START;
    if (c == CH_APOS) begin
      seg_push(c);
      mode = SCAN_QUOTED;
    end else if (c == CH_DOT) begin
      if (seg_count != 0 && !range_seen) begin
        seg_flush();
        step_out.push_back({1'b1, CH_BANG});
      end
      seg_count = 0;
    end else if (c == CH_COLON) begin
      range_seen = 1'b1;
      seg_flush();
      step_out.push_back({1'b1, CH_COLON});
      mode = SCAN_COLON;
    end else if (c == CH_SPACE) begin
      seg_flush();
      step_out.push_back({1'b1, CH_SEMI});
    end else begin
      seg_push(c);
    end
  endfunction

  // Convert one accepted character and queue the results it causes
  function void convert_char(logic [CH_W-1:0] c, bit fin);
    conv_result_t r;
    int n;
    step_out.delete();
    if (first_pending) begin
      first_pending = 1'b0;
      mode = SCAN_START;
      if (c != CH_DOLLAR) plain_char(c);
    end else begin
      case (mode)
        SCAN_QUOTED: begin
          seg_push(c);
          if (c == CH_APOS) mode = SCAN_QUOTE_SEEN;
        end
        SCAN_QUOTE_SEEN: begin
          if (c == CH_APOS) mode = SCAN_QUOTED;
          else plain_char(c);
        end
        SCAN_COLON: begin
          if (c == CH_DOLLAR && !fin) mode = SCAN_DOLLAR_HELD;
          else plain_char(c);
        end
        SCAN_DOLLAR_HELD: begin
          if (c == CH_DOT) seg_push(CH_DOLLAR);
          plain_char(c);
        end
        default: plain_char(c);
      endcase
    end
    if (fin) begin
      seg_flush();
      if (step_out.size() == 0) step_out.push_back({1'b0, CH_NONE});
    end
    n = step_out.size();
    for (int k = 0; k < n; k++) begin
      r.out_ch     = step_out[k][CH_W-1:0];
      r.has_char   = step_out[k][CH_W];
      r.run_end    = (k == n - 1);
      r.expr_end   = (k == n - 1) && fin;
      r.overflowed = dropped;
      converted_q.push_back(r);
    end
    if (fin) begin
      if (dropped) overflow_exprs++;
      clear_expr();
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  // Mostly no gap, some short, a few long
  function int pick_gap(bit en);
    int r;
    if (!en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function logic [CH_W-1:0] any_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'h0041 + 16'($urandom_range(0, 25));
      3: return 16'h0030 + 16'($urandom_range(0, 9));
      4: begin
        case ($urandom_range(0, 4))
          0: return CH_DOLLAR;
          1: return CH_DOT;
          2: return CH_COLON;
          3: return CH_SPACE;
          default: return CH_APOS;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // Character for a quoted sheet name; may be anything but an apostrophe
  function logic [CH_W-1:0] name_char();
    logic [CH_W-1:0] c;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: c = 16'h0061 + 16'($urandom_range(0, 25));
      4: c = CH_SPACE;
      5: c = CH_DOT;
      default: c = 16'($urandom);
    endcase
    return (c == CH_APOS) ? CH_COLON : c;
  endfunction

  function void add_sheet(int max_len);
    int n;
    n = $urandom_range(1, max_len);
    if ($urandom_range(0, 1)) begin
      expr_buf.push_back(CH_APOS);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          expr_buf.push_back(CH_APOS);
          expr_buf.push_back(CH_APOS);
        end else begin
          expr_buf.push_back(name_char());
        end
      end
      expr_buf.push_back(CH_APOS);
    end else begin
      for (int i = 0; i < n; i++) expr_buf.push_back(16'h0041 + 16'($urandom_range(0, 25)));
    end
    expr_buf.push_back(CH_DOT);
  endfunction

  function void add_cell();
    if ($urandom_range(0, 1)) expr_buf.push_back(CH_DOLLAR);
    repeat ($urandom_range(1, 2)) expr_buf.push_back(16'h0041 + 16'($urandom_range(0, 25)));
    if ($urandom_range(0, 1)) expr_buf.push_back(CH_DOLLAR);
    repeat ($urandom_range(1, 3)) expr_buf.push_back(16'h0030 + 16'($urandom_range(0, 9)));
  endfunction

  // Build a mostly well-formed reference list, sometimes noise
  function void gen_expr();
    expr_buf.delete();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 8)) expr_buf.push_back(any_char());
      return;
    end
    if ($urandom_range(0, 5) == 0) expr_buf.push_back(CH_DOLLAR);
    for (int p = 0; p < $urandom_range(1, 3); p++) begin
      if (p > 0) expr_buf.push_back(CH_SPACE);
      if ($urandom_range(0, 1)) add_sheet(6);
      add_cell();
      if ($urandom_range(0, 1)) begin
        expr_buf.push_back(CH_COLON);
        case ($urandom_range(0, 3))
          0: add_sheet(6);
          1: begin
            expr_buf.push_back(CH_DOLLAR);
            expr_buf.push_back(CH_DOT);
          end
          default: ;
        endcase
        add_cell();
      end
    end
    // occasionally break the tail: a stray character, which may be a quote or separator
    if ($urandom_range(0, 9) == 0) expr_buf.push_back(any_char());
  endfunction

  task send_char(logic [CH_W-1:0] c, bit fin);
    int gap;
    gap = pick_gap(tx_idle);
    if (gap > 0) begin
      chars_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    chars_if.ch         = c;
    chars_if.final_char = fin;
    chars_if.valid      = 1'b1;
    do @(posedge clk); while (!chars_if.ready);
    convert_char(c, fin);
    items_sent++;
    @(negedge clk);
  endtask

  task send_expr();
    for (int i = 0; i < expr_buf.size(); i++) send_char(expr_buf[i], i == expr_buf.size() - 1);
    exprs_sent++;
  endtask

  // ---------------------------------------------------------------- tests

  // Leading dollar, dot on an empty segment, sheet dot
  task test_sheet_dot();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    expr_buf = '{CH_DOLLAR, CH_DOT, 16'h0053, CH_DOT, 16'h0041};
    send_expr();
  endtask

  // Colon, dollar held before a dot, dot after a range, space, dollar dropped
  task test_range_rules();
    expr_buf = '{16'h0041, CH_COLON, CH_DOLLAR, CH_DOT, 16'h0042, CH_SPACE,
                 16'h0043, CH_COLON, CH_DOLLAR, 16'h0044};
    send_expr();
    // dollar as the final character after a colon is kept
    expr_buf = '{16'h0041, CH_COLON, CH_DOLLAR};
    send_expr();
  endtask

  // Doubled apostrophe in quotes, code-unit extremes
  task test_quotes();
    expr_buf = '{CH_APOS, 16'h0000, CH_APOS, CH_APOS, 16'hFFFF, CH_APOS, CH_DOT, 16'hFFFF};
    send_expr();
  endtask

  // Final step with nothing to emit gives a bare end marker
  task test_end_marker();
    expr_buf = '{CH_DOLLAR};
    send_expr();
  endtask

  task test_random_mix(int n);
    int target;
    target  = items_sent + n;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    while (items_sent < target) begin
      gen_expr();
      send_expr();
    end
  endtask

  task test_back_to_back(int n);
    int target;
    target  = items_sent + n;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    while (items_sent < target) begin
      gen_expr();
      send_expr();
    end
  endtask

  // Hold the receiver off while the sender keeps offering items
  task test_receiver_hold(int n);
    int target;
    target   = items_sent + n;
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    hold_req = 1'b1;
    while (items_sent < target) begin
      gen_expr();
      send_expr();
    end
  endtask

  // Segments that may exceed the buffer; the last one always does
  task test_long_segments();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int e = 0; e < 3; e++) begin
      expr_buf.delete();
      if (e == 2) begin
        repeat ($urandom_range(SEG_DEPTH + 1, SEG_DEPTH + 6))
          expr_buf.push_back(16'h0041 + 16'($urandom_range(0, 25)));
      end else begin
        add_sheet(SEG_DEPTH + 6);
        add_cell();
      end
      send_expr();
    end
  endtask

  // ---------------------------------------------------------------- receiver

  // Drive ready: long hold-off on request, else random stalls when rx_idle is set
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_if.ready = 1'b0;
    end else if (rx_idle && $urandom_range(0, 3) == 0) begin
      stall_left   = pick_gap(1'b1);
      res_if.ready = (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end else begin
      res_if.ready = 1'b1;
    end
  end

  // ---------------------------------------------------------------- checker

  function void check_field(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Compare each result item with the oldest expectation
  always @(posedge clk) begin
    conv_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (converted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $display("%0t: unexpected item: expected none, actual ch=%h has=%b", $time,
                   res_if.out_ch, res_if.has_char);
      end else begin
        want = converted_q.pop_front();
        check_field("out_ch", want.out_ch, res_if.out_ch);
        check_field("has_char", CH_W'(want.has_char), CH_W'(res_if.has_char));
        check_field("run_end", CH_W'(want.run_end), CH_W'(res_if.run_end));
        check_field("expr_end", CH_W'(want.expr_end), CH_W'(res_if.expr_end));
        check_field("overflowed", CH_W'(want.overflowed), CH_W'(res_if.overflowed));
        results_checked++;
      end
    end
  end

  // End the run when neither side moves for too long
  always @(posedge clk) begin
    if (rst || (chars_if.valid && chars_if.ready) || (res_if.valid && res_if.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst                 = 1'b1;
    chars_if.valid      = 1'b0;
    chars_if.ch         = '0;
    chars_if.final_char = 1'b0;
    res_if.ready        = 1'b0;
    tx_idle             = 1'b1;
    rx_idle             = 1'b1;
    hold_req            = 1'b0;
    hold_left           = 0;
    stall_left          = 0;
    stuck_cycles        = 0;
    items_sent          = 0;
    exprs_sent          = 0;
    results_checked     = 0;
    overflow_exprs      = 0;
    mismatches          = 0;
    clear_expr();
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    test_sheet_dot();
    test_range_rules();
    test_quotes();
    test_end_marker();
    test_random_mix(130);
    test_back_to_back(70);
    test_receiver_hold(40);
    test_long_segments();

    // Drain: wait for every expected item, then let the block settle
    chars_if.valid = 1'b0;
    rx_idle = 1'b0;
    while (converted_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (converted_q.size() != 0) mismatches++;

    $display("Summary: %0d characters in %0d expressions, %0d converted items checked",
             items_sent, exprs_sent, results_checked);
    $display("Summary: %0d expressions overflowed the segment buffer, %0d mismatches",
             overflow_exprs, mismatches);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
sv/crr_pkg.sv
sv/crr_in_if.sv
sv/crr_out_if.sv
sv/crr_datapath.sv
sv/crr_ctrl.sv
sv/cell_range_reference_import.sv
tb/sv/tb_top.sv
